>>> rtl/assert_macros.svh
// Assertion shorthands for the frame serialiser; clock and reset names are fixed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a property on every rising edge outside reset.
`define WSFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Forbid a condition on every rising edge outside reset.
`define WSFS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/wsfs_pkg.sv
package wsfs_pkg;

    localparam int MAX_PIXELS_DEF = 32;
    // pixel_count is six bits wide, so no frame ever reaches beyond this entry
    localparam int STORE_LIMIT    = 64;
    localparam int BITS_PER_PIXEL = 24;

    localparam logic [7:0] ONE_TICKS_RST   = 8'd160;
    localparam logic [7:0] ZERO_TICKS_RST  = 8'd80;
    localparam logic [7:0] LATCH_SLOTS_RST = 8'd50;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_SHOW  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] CFG_PIXEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_ONE_TICKS   = 2'd1;
    localparam logic [1:0] CFG_ZERO_TICKS  = 2'd2;
    localparam logic [1:0] CFG_LATCH_SLOTS = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic       slot_valid;
        logic [7:0] high_ticks;
        logic       frame_last;
        logic       busy_flag;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_COPY,
        ST_PRIME,
        ST_LOAD
    } state_t;

endpackage

>>> rtl/wsfs_ram.sv
module wsfs_ram import wsfs_pkg::*; #(
    parameter int WIDTH = BITS_PER_PIXEL,
    parameter int DEPTH = MAX_PIXELS_DEF
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ws2812_frame_serializer_top.sv
// An accepted transaction's result is registered in the output register in the next cycle.
// Throughput: writes and slot ticks one per cycle while the output is not stalled; a show that
// starts a frame with at least one pixel holds off input during the snapshot copy through the
// RAM read port and the fetch of the first pixel; a slot position wrap at 1024 holds off input
// while the first pixel is fetched again.
// Reset: asynchronous, active low; clears pixel valid bits and frame state, and loads configuration defaults.
module ws2812_frame_serializer_top import wsfs_pkg::*; #(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    `include "assert_macros.svh"

    localparam int DEPTH = (MAX_PIXELS > STORE_LIMIT) ? STORE_LIMIT : MAX_PIXELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PXW   = $clog2(DEPTH + 1);

    // configuration
    logic [5:0]     pixel_count_reg;
    logic [7:0]     one_ticks_reg;
    logic [7:0]     zero_ticks_reg;
    logic [7:0]     latch_slots_reg;

    // frame parameters latched at show
    logic [7:0]     frm_one_reg;
    logic [7:0]     frm_zero_reg;
    logic [10:0]    data_slots_reg;
    logic [10:0]    total_reg;
    logic [PXW-1:0] frm_px_reg;

    logic           sending_reg;
    logic           sending_next;
    logic [9:0]     pos_reg;
    logic [4:0]     bit_cnt_reg;
    logic [PXW-1:0] px_reg;
    logic [23:0]    sh_reg;
    logic [PXW-1:0] cp_reg;
    logic [DEPTH-1:0] vld_reg;
    logic           vld_q_reg;
    state_t         state_reg;
    state_t         state_next;

    logic           out_valid_reg;
    out_item_t      out_reg;
    out_item_t      result;

    logic           in_fire;
    logic [PXW-1:0] act_px;
    logic           write_go;
    logic           show_go;
    logic           tick_go;
    logic           in_data_region;
    logic [10:0]    pos_inc;
    logic           is_last;
    logic           wrap;
    logic [7:0]     slot_high;
    logic [10:0]    new_data_slots;
    logic [10:0]    new_total;
    logic [PXW-1:0] px_plus;
    logic [PXW-1:0] cp_minus;

    logic           store_we;
    logic [AW-1:0]  store_waddr;
    logic [AW-1:0]  store_raddr;
    logic [23:0]    store_rdata;
    logic           snap_we;
    logic [AW-1:0]  snap_waddr;
    logic [23:0]    snap_wdata;
    logic [AW-1:0]  snap_raddr;
    logic [23:0]    snap_rdata;

    wsfs_ram #(.WIDTH(BITS_PER_PIXEL), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata ({in_data.green, in_data.red, in_data.blue}),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    wsfs_ram #(.WIDTH(BITS_PER_PIXEL), .DEPTH(DEPTH)) u_snap (
        .clk   (clk),
        .we    (snap_we),
        .waddr (snap_waddr),
        .wdata (snap_wdata),
        .raddr (snap_raddr),
        .rdata (snap_rdata)
    );

    // clamp the chain length to the store size
    assign act_px = ({5'd0, pixel_count_reg} > 11'(MAX_PIXELS)) ? PXW'(DEPTH)
                                                                : PXW'(pixel_count_reg);

    assign in_fire  = in_valid && in_ready;
    assign write_go = in_fire && (in_data.mode == MODE_WRITE)
                      && (11'(in_data.pixel_index) < 11'(act_px));
    assign show_go  = in_fire && (in_data.mode == MODE_SHOW) && !sending_reg;
    assign tick_go  = in_fire && (in_data.mode == MODE_TICK) && sending_reg;

    assign new_data_slots = 11'(act_px) * 11'(BITS_PER_PIXEL);
    assign new_total      = new_data_slots + {3'd0, latch_slots_reg};

    assign in_data_region = {1'b0, pos_reg} < data_slots_reg;
    assign pos_inc        = {1'b0, pos_reg} + 11'd1;
    assign is_last        = pos_inc >= total_reg;
    assign wrap           = (pos_reg == 10'h3FF);
    assign slot_high      = in_data_region ? (sh_reg[23] ? frm_one_reg : frm_zero_reg)
                                           : 8'd0;
    assign px_plus        = px_reg + 1'b1;
    assign cp_minus       = cp_reg - 1'b1;

    always_comb
    begin
        sending_next = sending_reg;
        if (show_go)
        begin
            sending_next = (new_total != 11'd0);
        end
        else if (tick_go && is_last)
        begin
            sending_next = 1'b0;
        end
    end

    always_comb
    begin
        result.slot_valid = tick_go;
        result.high_ticks = tick_go ? slot_high : 8'd0;
        result.frame_last = tick_go && is_last;
        result.busy_flag  = sending_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (show_go && (act_px != '0))
                begin
                    state_next = ST_COPY;
                end
                else if (tick_go && !is_last && wrap)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_COPY:
            begin
                if (cp_reg == frm_px_reg)
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready    = 1'b0;
        store_we    = write_go;
        store_waddr = in_data.pixel_index[AW-1:0];
        store_raddr = cp_reg[AW-1:0];
        snap_we     = 1'b0;
        snap_waddr  = cp_minus[AW-1:0];
        snap_wdata  = vld_q_reg ? store_rdata : 24'd0;
        snap_raddr  = px_plus[AW-1:0];
        case (state_reg)
            ST_RUN:
            begin
                in_ready = !out_valid_reg || out_ready;
            end
            ST_COPY:
            begin
                snap_we = (cp_reg != '0);
            end
            ST_PRIME:
            begin
                snap_raddr = '0;
            end
            ST_LOAD:
            begin
                snap_raddr = px_plus[AW-1:0];
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= '0;
            one_ticks_reg   <= ONE_TICKS_RST;
            zero_ticks_reg  <= ZERO_TICKS_RST;
            latch_slots_reg <= LATCH_SLOTS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data[5:0];
                CFG_ONE_TICKS:   one_ticks_reg   <= cfg_data;
                CFG_ZERO_TICKS:  zero_ticks_reg  <= cfg_data;
                CFG_LATCH_SLOTS: latch_slots_reg <= cfg_data;
                default:         pixel_count_reg <= pixel_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            sending_reg    <= 1'b0;
            pos_reg        <= '0;
            bit_cnt_reg    <= '0;
            px_reg         <= '0;
            cp_reg         <= '0;
            vld_reg        <= '0;
            vld_q_reg      <= 1'b0;
            frm_one_reg    <= '0;
            frm_zero_reg   <= '0;
            data_slots_reg <= '0;
            total_reg      <= '0;
            frm_px_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sending_reg <= sending_next;
            vld_q_reg   <= vld_reg[cp_reg[AW-1:0]];

            if (write_go)
            begin
                vld_reg[in_data.pixel_index[AW-1:0]] <= 1'b1;
            end

            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (show_go)
            begin
                frm_one_reg    <= one_ticks_reg;
                frm_zero_reg   <= zero_ticks_reg;
                data_slots_reg <= new_data_slots;
                total_reg      <= new_total;
                frm_px_reg     <= act_px;
                pos_reg        <= '0;
                bit_cnt_reg    <= '0;
                px_reg         <= '0;
                cp_reg         <= '0;
            end
            else if (state_reg == ST_COPY)
            begin
                cp_reg <= cp_reg + 1'b1;
            end
            else if (tick_go)
            begin
                if (is_last || wrap)
                begin
                    // restart the walk from the first pixel
                    pos_reg     <= '0;
                    bit_cnt_reg <= '0;
                    px_reg      <= '0;
                end
                else
                begin
                    pos_reg <= pos_inc[9:0];
                    if (in_data_region)
                    begin
                        if (bit_cnt_reg == 5'(BITS_PER_PIXEL - 1))
                        begin
                            bit_cnt_reg <= '0;
                            px_reg      <= px_plus;
                        end
                        else
                        begin
                            bit_cnt_reg <= bit_cnt_reg + 5'd1;
                        end
                    end
                end
            end
        end
    end

    // pixel shift register: load at a pixel boundary, shift one bit per data slot
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            sh_reg <= snap_rdata;
        end
        else if (tick_go && in_data_region && !is_last)
        begin
            if (bit_cnt_reg == 5'(BITS_PER_PIXEL - 1))
            begin
                sh_reg <= snap_rdata;
            end
            else
            begin
                sh_reg <= {sh_reg[22:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `WSFS_ASSERT(a_last_ends_frame, (tick_go && is_last) |=> !sending_reg,
                 "frame still busy after its last slot")
    `WSFS_ASSERT(a_copy_in_frame, (state_reg == ST_COPY) |-> sending_reg,
                 "snapshot copy outside a frame")
    `WSFS_ASSERT(a_pos_in_frame, sending_reg |-> ({1'b0, pos_reg} < total_reg),
                 "slot position beyond frame length")
    `WSFS_NEVER(a_idle_slot_clean, out_valid && !out_data.slot_valid
                && (out_data.frame_last || (out_data.high_ticks != 8'd0)),
                "non-slot result carries slot data")

endmodule
